### sv/lav_pkg.sv
// Look-at view matrix: shared widths, item type and state enums.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lav_pkg;

  localparam int FRAC_BITS = 16;              // fraction bits of all Q values
  localparam int PW   = 32;                   // port field width
  localparam int DW   = PW + 1;               // target - position, full precision
  localparam int SW   = 30;                   // scaled magnitude width
  localparam int SQW  = 2 * SW + 2;           // sum of three squares
  localparam int RTW  = SQW + 2;              // square root working width
  localparam int LW   = SW + 1;               // vector length width
  localparam int QB   = FRAC_BITS + 1;        // quotient bits of a unit component
  localparam int UW   = FRAC_BITS + 2;        // signed unit component width
  localparam int NW   = SW + FRAC_BITS + 1;   // dividend width
  localparam int AW   = UW + PW + 2;          // multiply-accumulate width
  localparam int CNTW = $clog2(QB + 1);

  typedef logic [2:0][PW-1:0] lav_pvec_t;
  typedef logic [2:0][DW-1:0] lav_dvec_t;
  typedef logic [2:0][UW-1:0] lav_uvec_t;

  typedef struct packed {
    lav_pvec_t pos;
    lav_dvec_t dir;
    logic      degen;
  } lav_item_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DIV, N_DONE
  } lav_nstate_e;

  typedef enum logic [2:0] {
    B_LOAD, B_NORM_D, B_NORM_R, B_CROSS, B_DOT, B_EMIT
  } lav_bstate_e;

endpackage
`default_nettype wire

### sv/lav_front.sv
// Front end: takes a request, forms the direction and flags the degenerate case.
// Depends on lav_pkg.
`default_nettype none
module lav_front (
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [lav_pkg::PW-1:0] pos_x_i,
  input  wire logic [lav_pkg::PW-1:0] pos_y_i,
  input  wire logic [lav_pkg::PW-1:0] pos_z_i,
  input  wire logic [lav_pkg::PW-1:0] tgt_x_i,
  input  wire logic [lav_pkg::PW-1:0] tgt_y_i,
  input  wire logic [lav_pkg::PW-1:0] tgt_z_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output lav_pkg::lav_item_t        item_o
);
  import lav_pkg::*;

  logic signed [DW-1:0] dx, dy, dz;

  assign dx = DW'($signed(tgt_x_i)) - DW'($signed(pos_x_i));
  assign dy = DW'($signed(tgt_y_i)) - DW'($signed(pos_y_i));
  assign dz = DW'($signed(tgt_z_i)) - DW'($signed(pos_z_i));

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.pos   = {pos_z_i, pos_y_i, pos_x_i};
    item_o.dir   = {dz, dy, dx};
    // no horizontal component: zero length or straight up/down
    item_o.degen = (dx == '0) && (dz == '0);
  end

endmodule
`default_nettype wire

### sv/lav_queue.sv
// Two-entry queue between front end and back end.
// Depends on lav_pkg.
`default_nettype none
module lav_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire lav_pkg::lav_item_t item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output lav_pkg::lav_item_t      item_o
);
  import lav_pkg::*;

  lav_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_q];
  // consumer ready only counts when an entry is actually there
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop)    rd_q <= !rd_q;
      if (push_i && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

endmodule
`default_nettype wire

### sv/lav_norm.sv
// Vector normalizer: scale, sum of squares, bitwise square root, then one
// restoring divide per component. Depends on lav_pkg.
`default_nettype none
module lav_norm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire lav_pkg::lav_dvec_t vec_i,
  output logic                    done_o,
  output lav_pkg::lav_uvec_t      unit_o
);
  import lav_pkg::*;

  lav_nstate_e state_q, state_d;

  lav_pvec_t       mag_q, mag_d;
  logic [2:0]      neg_q, neg_d;
  logic [SQW-1:0]  sum_q, sum_d;
  logic [RTW-1:0]  res_q, res_d, bit_q, bit_d;
  logic [1:0]      idx_q, idx_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [LW-1:0]   rem_q, rem_d;
  logic [QB-1:0]   lo_q, lo_d, quo_q, quo_d;
  lav_uvec_t       unit_q, unit_d;

  lav_dvec_t        absv;
  logic [PW-1:0]    mx;
  logic [2*SW-1:0]  sq;
  logic [RTW-1:0]   trial;
  logic             take;
  logic [LW-1:0]    len;
  logic [NW-1:0]    num;
  logic [LW:0]      rem2;
  logic             ge;
  logic [LW-1:0]    rnext;
  logic [QB-1:0]    qn;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absv[i] = vec_i[i][DW-1] ? DW'(-$signed(vec_i[i])) : vec_i[i];
    end
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
  end

  assign sq    = mag_q[idx_q][SW-1:0] * mag_q[idx_q][SW-1:0];
  assign trial = res_q + bit_q;
  assign take  = {2'b00, sum_q} >= trial;
  assign len   = res_q[LW-1:0];
  assign num   = NW'({mag_q[idx_q][SW-1:0], {FRAC_BITS{1'b0}}}) + NW'(len[LW-1:1]);
  assign rem2  = {rem_q, lo_q[QB-1]};
  assign ge    = rem2 >= {1'b0, len};
  assign rnext = ge ? LW'(rem2 - {1'b0, len}) : rem2[LW-1:0];
  assign qn    = {quo_q[QB-2:0], ge};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (start_i) state_d = N_SCALE;
      N_SCALE: begin
        if (mx == '0) state_d = N_DONE;
        else if (mx[PW-1:SW] == '0 && mx[SW-1]) state_d = N_SQ;
      end
      N_SQ:    if (idx_q == 2'd2) state_d = N_SQRT;
      N_SQRT:  if (bit_q[0]) state_d = N_DIV;
      N_DIV:   if (cnt_q == CNTW'(QB) && idx_q == 2'd2) state_d = N_DONE;
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mag_d  = mag_q;
    neg_d  = neg_q;
    sum_d  = sum_q;
    res_d  = res_q;
    bit_d  = bit_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    unit_d = unit_q;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            mag_d[i] = absv[i][PW-1:0];
            neg_d[i] = vec_i[i][DW-1];
          end
          unit_d = '0;
        end
      end
      N_SCALE: begin
        // one bit a cycle until the largest magnitude is in [2^29, 2^30)
        if (mx == '0) begin
          unit_d = '0;
        end else if (mx[PW-1:SW] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!mx[SW-1]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          idx_d = 2'd0;
          sum_d = '0;
        end
      end
      N_SQ: begin
        sum_d = sum_q + SQW'(sq);
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          idx_d = 2'd0;
          res_d = '0;
          bit_d = RTW'(1) << SQW;
          cnt_d = '0;
        end
      end
      N_SQRT: begin
        if (take) begin
          sum_d = sum_q - trial[SQW-1:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      N_DIV: begin
        if (cnt_q == '0) begin
          rem_d = LW'(num[NW-1:QB]);
          lo_d  = num[QB-1:0];
          quo_d = '0;
          cnt_d = CNTW'(1);
        end else begin
          rem_d = rnext;
          lo_d  = lo_q << 1;
          quo_d = qn;
          if (cnt_q == CNTW'(QB)) begin
            unit_d[idx_q] = neg_q[idx_q] ? UW'(-$signed({1'b0, qn})) : UW'(qn);
            cnt_d = '0;
            idx_d = idx_q + 2'd1;
          end else begin
            cnt_d = cnt_q + CNTW'(1);
          end
        end
      end
      N_DONE: ;
      default: ;
    endcase
  end

  assign done_o = (state_q == N_DONE);
  assign unit_o = unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quo_q  <= quo_d;
    unit_q <= unit_d;
  end

endmodule
`default_nettype wire

### sv/lav_back.sv
// Back end: sequences the normalizer, forms U and the translations on one
// multiply-accumulate, and drives the row output register. Depends on lav_pkg.
`default_nettype none
module lav_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_valid_i,
  input  wire lav_pkg::lav_item_t    item_i,
  output logic                       item_ready_o,
  output logic                       norm_start_o,
  output lav_pkg::lav_dvec_t         norm_vec_o,
  input  wire logic                  norm_done_i,
  input  wire lav_pkg::lav_uvec_t    norm_unit_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 row_index_o,
  output logic [lav_pkg::PW-1:0]     elem_x_o,
  output logic [lav_pkg::PW-1:0]     elem_y_o,
  output logic [lav_pkg::PW-1:0]     elem_z_o,
  output logic [lav_pkg::PW-1:0]     elem_shift_o,
  output logic                       last_row_o,
  output logic                       degenerate_o
);
  import lav_pkg::*;

  localparam logic [2:0] CrossLast = 3'd4;
  localparam logic [1:0] RowLast   = 2'd2;
  localparam logic [1:0] DotLast   = 2'd3;

  lav_bstate_e state_q, state_d;

  lav_pvec_t              pos_q;
  lav_dvec_t              dir_q;
  logic                   degen_q;
  lav_uvec_t              dv_q, rv_q, uv_q;
  logic [2:0][PW-1:0]     shift_q;
  logic signed [AW-1:0]   acc_q;
  logic [2:0]             cnt_q;
  logic [1:0]             row_q, k_q;
  logic                   start_q;

  logic                   out_valid_q;
  logic [1:0]             row_index_q;
  logic [PW-1:0]          elem_x_q, elem_y_q, elem_z_q, elem_shift_q;
  logic                   last_row_q, degenerate_q;

  lav_dvec_t              hvec;
  lav_uvec_t              rowv;
  logic signed [UW-1:0]   mul_a;
  logic signed [PW-1:0]   mul_b;
  logic signed [AW-1:0]   base;
  logic                   sub;
  logic signed [UW+PW-1:0] prod;
  logic signed [AW-1:0]   acc_n;
  logic [AW-1:0]          mg, rm;
  logic signed [AW-1:0]   rnd, nrnd;
  logic [PW-1:0]          sat;
  logic                   slot_free;
  logic                   accept;

  assign hvec[0] = dir_q[2];
  assign hvec[1] = '0;
  assign hvec[2] = DW'(-$signed(dir_q[0]));

  assign norm_vec_o   = (state_q == B_NORM_R) ? hvec : dir_q;
  assign norm_start_o = start_q;
  assign item_ready_o = (state_q == B_LOAD);
  assign accept       = item_ready_o && item_valid_i;
  assign slot_free    = !out_valid_q || out_ready_i;

  always_comb begin
    case (row_q)
      2'd0:    rowv = rv_q;
      2'd1:    rowv = uv_q;
      default: rowv = dv_q;
    endcase
  end

  // operand select for the shared multiply-accumulate
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    base  = '0;
    sub   = 1'b0;
    if (state_q == B_CROSS) begin
      case (cnt_q)
        3'd0: begin
          mul_a = $signed(dv_q[1]);
          mul_b = PW'($signed(rv_q[2]));
        end
        3'd1: begin
          mul_a = $signed(dv_q[2]);
          mul_b = PW'($signed(rv_q[0]));
        end
        3'd2: begin
          mul_a = $signed(dv_q[0]);
          mul_b = PW'($signed(rv_q[2]));
          base  = acc_q;
          sub   = 1'b1;
        end
        3'd3: begin
          mul_a = $signed(dv_q[1]);
          mul_b = PW'($signed(rv_q[0]));
          sub   = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (k_q)
        2'd0: begin
          mul_a = $signed(rowv[0]);
          mul_b = $signed(pos_q[0]);
        end
        2'd1: begin
          mul_a = $signed(rowv[1]);
          mul_b = $signed(pos_q[1]);
          base  = acc_q;
        end
        2'd2: begin
          mul_a = $signed(rowv[2]);
          mul_b = $signed(pos_q[2]);
          base  = acc_q;
        end
        default: ;
      endcase
    end
  end

  assign prod  = mul_a * mul_b;
  assign acc_n = sub ? base - AW'(prod) : base + AW'(prod);

  // round to FRAC_BITS, half away from zero, then negate and saturate
  assign mg   = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign rm   = (mg + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rnd  = acc_q[AW-1] ? -$signed(rm) : $signed(rm);
  assign nrnd = -rnd;

  always_comb begin
    if (nrnd[AW-1:PW-1] == '0 || nrnd[AW-1:PW-1] == '1) sat = nrnd[PW-1:0];
    else if (nrnd[AW-1]) sat = {1'b1, {(PW-1){1'b0}}};
    else                 sat = {1'b0, {(PW-1){1'b1}}};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_LOAD:   if (item_valid_i) state_d = item_i.degen ? B_EMIT : B_NORM_D;
      B_NORM_D: if (norm_done_i) state_d = B_NORM_R;
      B_NORM_R: if (norm_done_i) state_d = B_CROSS;
      B_CROSS:  if (cnt_q == CrossLast) state_d = B_DOT;
      B_DOT:    if (k_q == DotLast && row_q == RowLast) state_d = B_EMIT;
      B_EMIT:   if (slot_free && row_q == RowLast) state_d = B_LOAD;
      default:  state_d = B_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_LOAD;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (accept && !item_i.degen) || (state_q == B_NORM_D && norm_done_i);
      if (state_q == B_EMIT && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_LOAD: begin
        if (item_valid_i) begin
          pos_q   <= item_i.pos;
          dir_q   <= item_i.dir;
          degen_q <= item_i.degen;
          row_q   <= 2'd0;
        end
      end
      B_NORM_D: if (norm_done_i) dv_q <= norm_unit_i;
      B_NORM_R: begin
        if (norm_done_i) begin
          rv_q  <= norm_unit_i;
          cnt_q <= 3'd0;
        end
      end
      B_CROSS: begin
        acc_q <= acc_n;
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd1) uv_q[0] <= rnd[UW-1:0];
        if (cnt_q == 3'd3) uv_q[1] <= rnd[UW-1:0];
        if (cnt_q == CrossLast) begin
          uv_q[2] <= rnd[UW-1:0];
          row_q   <= 2'd0;
          k_q     <= 2'd0;
        end
      end
      B_DOT: begin
        acc_q <= acc_n;
        k_q   <= k_q + 2'd1;
        if (k_q == DotLast) begin
          shift_q[row_q] <= sat;
          row_q <= (row_q == RowLast) ? 2'd0 : row_q + 2'd1;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          row_index_q  <= row_q;
          elem_x_q     <= degen_q ? '0 : PW'($signed(rowv[0]));
          elem_y_q     <= degen_q ? '0 : PW'($signed(rowv[1]));
          elem_z_q     <= degen_q ? '0 : PW'($signed(rowv[2]));
          elem_shift_q <= degen_q ? '0 : shift_q[row_q];
          last_row_q   <= (row_q == RowLast);
          degenerate_q <= degen_q;
          row_q        <= row_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign row_index_o  = row_index_q;
  assign elem_x_o     = elem_x_q;
  assign elem_y_o     = elem_y_q;
  assign elem_z_o     = elem_z_q;
  assign elem_shift_o = elem_shift_q;
  assign last_row_o   = last_row_q;
  assign degenerate_o = degenerate_q;

endmodule
`default_nettype wire

### sv/look_at_view_matrix_unit.sv
// Look-at view matrix with up fixed at +Y, Q16.16 in and out.
// A degenerate request skips the normalizer. Any other request runs two
// normalizations, each a scaling, a sum of squares, a bitwise square root and
// restoring divides, then the cross and dot products. Rows are emitted one per
// cycle while the receiver is ready. The back end works on one request at a
// time; the queue holds further requests meanwhile. Reset clears the queue and FSMs.
`default_nettype none
module look_at_view_matrix_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [lav_pkg::PW-1:0] pos_x_i,
  input  wire logic [lav_pkg::PW-1:0] pos_y_i,
  input  wire logic [lav_pkg::PW-1:0] pos_z_i,
  input  wire logic [lav_pkg::PW-1:0] tgt_x_i,
  input  wire logic [lav_pkg::PW-1:0] tgt_y_i,
  input  wire logic [lav_pkg::PW-1:0] tgt_z_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 row_index_o,
  output logic [lav_pkg::PW-1:0]     elem_x_o,
  output logic [lav_pkg::PW-1:0]     elem_y_o,
  output logic [lav_pkg::PW-1:0]     elem_z_o,
  output logic [lav_pkg::PW-1:0]     elem_shift_o,
  output logic                       last_row_o,
  output logic                       degenerate_o
);
  import lav_pkg::*;

  // front end -> queue
  logic      push, full;
  lav_item_t front_item;
  // queue -> back end
  logic      q_valid, q_pop;
  lav_item_t q_item;
  // back end <-> normalizer
  logic      norm_start, norm_done;
  lav_dvec_t norm_vec;
  lav_uvec_t norm_unit;

  // Front end: direction and degenerate flag, one request per cycle while
  // the queue has room.
  lav_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .tgt_x_i    (tgt_x_i),
    .tgt_y_i    (tgt_y_i),
    .tgt_z_i    (tgt_z_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // Two requests can wait here while the back end is busy.
  lav_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Shared normalizer: used for D first, then R.
  lav_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .unit_o  (norm_unit)
  );

  // Back end: U, translations and the row output register. The next request
  // is pulled while the last row still waits on the output.
  lav_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_ready_o (q_pop),
    .norm_start_o (norm_start),
    .norm_vec_o   (norm_vec),
    .norm_done_i  (norm_done),
    .norm_unit_i  (norm_unit),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .row_index_o  (row_index_o),
    .elem_x_o     (elem_x_o),
    .elem_y_o     (elem_y_o),
    .elem_z_o     (elem_z_o),
    .elem_shift_o (elem_shift_o),
    .last_row_o   (last_row_o),
    .degenerate_o (degenerate_o)
  );

endmodule
`default_nettype wire

### verif/look_at_view_matrix_unit_tb.sv
// Testbench for look_at_view_matrix_unit: directed and random camera/target requests.
// Self-checking against a behavioral look-at predictor; depends on lav_pkg and the DUT.
`timescale 1ns / 100ps
`default_nettype none
module look_at_view_matrix_unit_tb;
  import lav_pkg::*;

  localparam int FB = FRAC_BITS;

  typedef struct {
    logic [1:0]    row;
    logic [PW-1:0] ex, ey, ez, sh;
    logic          last, degen;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [PW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [PW-1:0] tgt_x_i = '0, tgt_y_i = '0, tgt_z_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [1:0]    row_index_o;
  logic [PW-1:0] elem_x_o, elem_y_o, elem_z_o, elem_shift_o;
  logic          last_row_o, degenerate_o;

  look_at_view_matrix_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  row_t expected_rows[$];
  int   fail_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // integer sqrt, floor
  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_q(input longint x);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = (m + (64'd1 << (FB - 1))) >> FB;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // unit vector: block-float scale into [2^29,2^30), sqrt, rounded divide
  task automatic unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = isqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic predict_view_rows(input logic [PW-1:0] pin[3], input logic [PW-1:0] tin[3]);
    longint p[3], d[3], h[3], rv[3], uv[3], dv[3], mat[3][3], acc;
    row_t   r;
    logic   degen;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'(signed'(pin[i]));
      d[i] = longint'(signed'(tin[i])) - p[i];
    end
    degen = (d[0] == 0) && (d[2] == 0);
    if (!degen) begin
      unit_vec(d, dv);
      h = '{d[2], 0, -d[0]};
      unit_vec(h, rv);
      rv[1] = 0;
      uv[0] = round_q(dv[1] * rv[2]);
      uv[1] = round_q(dv[2] * rv[0] - dv[0] * rv[2]);
      uv[2] = round_q(-(dv[1] * rv[0]));
      mat[0] = rv;
      mat[1] = uv;
      mat[2] = dv;
    end
    for (int k = 0; k < 3; k++) begin
      r.row = k[1:0];
      r.last = (k == 2);
      r.degen = degen;
      if (degen) begin
        r.ex = '0; r.ey = '0; r.ez = '0; r.sh = '0;
      end else begin
        acc = mat[k][0] * p[0] + mat[k][1] * p[1] + mat[k][2] * p[2];
        r.ex = mat[k][0][31:0];
        r.ey = mat[k][1][31:0];
        r.ez = mat[k][2][31:0];
        acc = clamp32(round_q(-acc));
        r.sh = acc[31:0];
      end
      expected_rows.push_back(r);
    end
  endtask

  // send one request, random idle beforehand
  task automatic send_request(input logic [PW-1:0] px, py, pz, tx, ty, tz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    tgt_x_i <= tx; tgt_y_i <= ty; tgt_z_i <= tz;
    predict_view_rows('{px, py, pz}, '{tx, ty, tz});
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row idx=%0d", $time, row_index_o);
        fail_cnt++;
      end else begin
        row_t e;
        e = expected_rows.pop_front();
        if (e.row !== row_index_o || e.ex !== elem_x_o || e.ey !== elem_y_o ||
            e.ez !== elem_z_o || e.sh !== elem_shift_o || e.last !== last_row_o ||
            e.degen !== degenerate_o) begin
          $display("%0t: mismatch exp row=%0d x=%h y=%h z=%h sh=%h last=%b dg=%b",
                   $time, e.row, e.ex, e.ey, e.ez, e.sh, e.last, e.degen);
          $display("%0t:          got row=%0d x=%h y=%h z=%h sh=%h last=%b dg=%b",
                   $time, row_index_o, elem_x_o, elem_y_o, elem_z_o, elem_shift_o,
                   last_row_o, degenerate_o);
          fail_cnt++;
        end
      end
    end
  end

  function automatic logic [PW-1:0] rnd_coord();
    case ($urandom_range(5))
      0:       return $urandom_range(255) << FB;          // small integers
      1:       return -($urandom_range(255) << FB);
      2:       return $urandom_range(2047) - 1024;        // sub-unit
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic [PW-1:0] mx, mn, one;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    send_request(0, 0, 0, 0, 0, one);                  // looking down +z
    send_request(0, 0, 0, one, 0, 0);
    send_request(0, 0, 0, -one, 0, -one);
    send_request(0, 0, 0, 0, 0, 0);                    // zero direction
    send_request(one, 0, one, one, 5 * one, one);      // straight up
    send_request(one, mx, one, one, mn, one);          // straight down, extreme
    send_request(mx, mx, mx, mn, mn, mn);              // largest difference
    send_request(mn, mn, mn, mx, mx, mx);
    send_request(mx, mn, mx, mx - 1, mx, mx);
    send_request(0, 0, 0, 1, 0, 0);                    // tiny direction
    send_request(0, 0, 0, 0, mx, 1);                   // nearly vertical
    send_request(mx, mx, mx, 0, 0, 0);                 // shift saturation
    send_request(mn, mn, mn, mn + 1, mn, mn);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(3 * one, 2 * one, one, -one, 7 * one, 4 * one);
  endtask

  task automatic test_random(input int n);
    logic [PW-1:0] p[3], t[3];
    for (int i = 0; i < n; i++) begin
      foreach (p[k]) p[k] = rnd_coord();
      foreach (t[k]) t[k] = rnd_coord();
      if ($urandom_range(15) == 0) begin                // degenerate case
        t[0] = p[0];
        t[2] = p[2];
      end
      send_request(p[0], p[1], p[2], t[0], t[1], t[2]);
    end
  endtask

  task automatic drain_rows();
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 23;
    recv_idle_pct = 50;
    test_directed();
    test_random(70);
    send_idle_pct = 50;
    recv_idle_pct = 23;
    test_random(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(70);
    drain_rows();
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog: a time limit for ~250 items, with a wide margin
  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
